// File: rtl/vaa_pkg.sv
package vaa_pkg;

  localparam int LEN_BITS   = 48;
  localparam int ANGLE_BITS = 25;

  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
  localparam logic [30:0] LIMIT_RESET = 31'd10000;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  localparam logic [1:0] UNIT_RAD  = 2'd0;
  localparam logic [1:0] UNIT_DEG  = 2'd1;
  localparam logic [1:0] UNIT_GRAD = 2'd2;

  localparam logic CFG_UNIT  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_CLEAR, OP_PHASE, OP_ROT_INIT, OP_ROT, OP_SCALE, OP_ACC,
    OP_VEC_INIT, OP_VEC, OP_MAG, OP_FIN, OP_DIV_INIT, OP_DIV, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic clear_item;
    logic out_free;
  } status_t;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/vaa_if.sv
interface vaa_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] angle_in;
  logic signed [31:0] weight;

  modport source(output valid, req_type, angle_in, weight, input ready);
  modport sink(input valid, req_type, angle_in, weight, output ready);
endinterface

interface vaa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_total;
  logic [24:0] mean_angle;
  logic [47:0] total_length;
  logic [47:0] mean_length;
  logic        overflow_flag;
  logic        singular_flag;

  modport source(output valid, sample_total, mean_angle, total_length, mean_length,
                 overflow_flag, singular_flag, input ready);
  modport sink(input valid, sample_total, mean_angle, total_length, mean_length,
               overflow_flag, singular_flag, output ready);
endinterface

// File: rtl/vaa_datapath.sv
module vaa_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [30:0]          cfg_data,
  input  vaa_pkg::cmd_t        cmd,
  output vaa_pkg::status_t     status,
  input  logic                 in_req_type,
  input  logic signed [31:0]   in_angle,
  input  logic signed [31:0]   in_weight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_total,
  output logic [24:0]          out_angle,
  output logic [47:0]          out_length,
  output logic [47:0]          out_mean,
  output logic                 out_ovf,
  output logic                 out_sing
);
  import vaa_pkg::*;

  localparam int GUARD_L = (ACC_BITS < 61) ? 61 - ACC_BITS : 0;
  localparam int GUARD_R = (ACC_BITS > 61) ? ACC_BITS - 61 : 0;
  localparam int CW = ((ACC_BITS > 31 + FRAC_BITS) ? ACC_BITS : 31 + FRAC_BITS) + 2;

  logic [1:0]  unit;
  logic [30:0] limit;
  logic        req_r;
  logic signed [31:0] angle_r, weight_r;
  logic [63:0] prod;
  logic        flip;
  logic signed [33:0] rx, ry, rz;
  logic signed [65:0] px, py;
  logic signed [ACC_BITS-1:0] sum_x, sum_y;
  logic [31:0] count;
  logic        sing_r, ovf_r, sx_neg, sy_neg;
  logic signed [63:0] vx, vy;
  logic signed [33:0] vz;
  logic [31:0] pa;
  logic [63:0] mh;
  logic [59:0] ml;
  logic [47:0] total_r, quo;
  logic [31:0] rem;
  logic [24:0] angle_q;

  logic [29:0] phase_mul;
  logic signed [63:0] phase_prod;
  logic [31:0] ph;
  logic [33:0] at;
  logic signed [33:0] c_val, s_val;
  logic signed [ACC_BITS:0] sx_sum, sy_sum;
  logic signed [ACC_BITS-1:0] sx_sat, sy_sat, acc_max, acc_min;
  logic signed [CW-1:0] lim_w, sx_w, sy_w;
  logic [ACC_BITS-1:0] ax, ay;
  logic signed [33:0] zc;
  logic [31:0] p_val;
  logic [63:0] ux, r_sum, mag_val;
  logic [30:0] ang_mul;
  logic [63:0] ang_sh;
  logic [32:0] dtry;

  assign status.clear_item = (req_r == REQ_CLEAR);
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    case (unit)
      UNIT_DEG:  phase_mul = 30'd11930465;
      UNIT_GRAD: phase_mul = 30'd10737418;
      default:   phase_mul = 30'd683565276;
    endcase
    case (unit)
      UNIT_DEG:  ang_mul = 31'd360;
      UNIT_GRAD: ang_mul = 31'd400;
      default:   ang_mul = TWO_PI_Q28;
    endcase
  end

  assign phase_prod = 64'(angle_r) * 64'($signed({1'b0, phase_mul}));
  assign ph = prod[FRAC_BITS +: 32];
  assign at = {2'b00, atan_entry(cmd.step)};
  assign c_val = flip ? -rx : rx;
  assign s_val = flip ? -ry : ry;

  assign acc_max = {1'b0, {(ACC_BITS-1){1'b1}}};
  assign acc_min = {1'b1, {(ACC_BITS-1){1'b0}}};
  assign sx_sum = (ACC_BITS+1)'(sum_x) + (ACC_BITS+1)'($signed(px[65:30]));
  assign sy_sum = (ACC_BITS+1)'(sum_y) + (ACC_BITS+1)'($signed(py[65:30]));
  assign sx_sat = (sx_sum[ACC_BITS] != sx_sum[ACC_BITS-1]) ?
                  (sx_sum[ACC_BITS] ? acc_min : acc_max) : sx_sum[ACC_BITS-1:0];
  assign sy_sat = (sy_sum[ACC_BITS] != sy_sum[ACC_BITS-1]) ?
                  (sy_sum[ACC_BITS] ? acc_min : acc_max) : sy_sum[ACC_BITS-1:0];

  assign lim_w = CW'(limit) << FRAC_BITS;
  assign sx_w  = CW'(sum_x);
  assign sy_w  = CW'(sum_y);
  assign ax = sum_x[ACC_BITS-1] ? ACC_BITS'(-sum_x) : sum_x;
  assign ay = sum_y[ACC_BITS-1] ? ACC_BITS'(-sum_y) : sum_y;

  always_comb begin
    if (vz < 0) zc = '0;
    else if (vz > 34'sd1073741824) zc = 34'sd1073741824;
    else zc = vz;
    p_val = zc[31:0];
    if (sx_neg) p_val = 32'h80000000 - p_val;
    if (sy_neg) p_val = 32'd0 - p_val;
  end

  assign ux = vx[63] ? 64'd0 : vx;
  assign r_sum = mh + 64'(ml >> 30);

  always_comb begin
    if (GUARD_R != 0 && (r_sum >> (64 - GUARD_R)) != 64'd0) mag_val = '1;
    else mag_val = (r_sum >> GUARD_L) << GUARD_R;
  end

  assign ang_sh = (unit == UNIT_DEG || unit == UNIT_GRAD) ?
                  prod >> (32 - FRAC_BITS) : prod >> (60 - FRAC_BITS);
  assign dtry = {rem, quo[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      unit      <= UNIT_RAD;
      limit     <= LIMIT_RESET;
      sum_x     <= '0;
      sum_y     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_UNIT) unit <= cfg_data[1:0];
        else limit <= cfg_data;
      end
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.op == OP_CLEAR) begin
        sum_x <= '0;
        sum_y <= '0;
        count <= '0;
      end else if (cmd.op == OP_ACC) begin
        sum_x <= sx_sat;
        sum_y <= sy_sat;
        if (count != 32'hFFFFFFFF) count <= count + 32'd1;
      end
    end

    case (cmd.op)
      OP_LOAD: begin
        req_r    <= in_req_type;
        angle_r  <= in_angle;
        weight_r <= in_weight;
      end
      OP_PHASE: prod <= phase_prod;
      OP_ROT_INIT: begin
        flip <= ph[31] ^ ph[30];
        rx   <= 34'sd652032874;
        ry   <= '0;
        rz   <= 34'($signed({ph[31] ^ ph[31] ^ ph[30], ph[30:0]}));
      end
      OP_ROT: begin
        if (!rz[33]) begin
          rx <= rx - (ry >>> cmd.step);
          ry <= ry + (rx >>> cmd.step);
          rz <= rz - $signed(at);
        end else begin
          rx <= rx + (ry >>> cmd.step);
          ry <= ry - (rx >>> cmd.step);
          rz <= rz + $signed(at);
        end
      end
      OP_SCALE: begin
        px <= 66'(c_val) * 66'(weight_r);
        py <= 66'(s_val) * 66'(weight_r);
      end
      OP_VEC_INIT: begin
        sing_r <= (sum_x == 0) && (sum_y == 0);
        ovf_r  <= (sx_w > lim_w) || (sx_w < -lim_w) || (sy_w > lim_w) || (sy_w < -lim_w);
        sx_neg <= sum_x[ACC_BITS-1];
        sy_neg <= sum_y[ACC_BITS-1];
        vx <= (64'(ax) << GUARD_L) >> GUARD_R;
        vy <= (64'(ay) << GUARD_L) >> GUARD_R;
        vz <= '0;
      end
      OP_VEC: begin
        if (vy > 0) begin
          vx <= vx + (vy >>> cmd.step);
          vy <= vy - (vx >>> cmd.step);
          vz <= vz + $signed(at);
        end else begin
          vx <= vx - (vy >>> cmd.step);
          vy <= vy + (vx >>> cmd.step);
          vz <= vz - $signed(at);
        end
      end
      OP_MAG: begin
        pa <= p_val;
        mh <= 64'(ux[63:30]) * 64'(GAIN_Q30);
        ml <= 60'(ux[29:0]) * 60'(GAIN_Q30);
      end
      OP_FIN: begin
        prod <= 64'(pa) * 64'(ang_mul);
        if (sing_r || count == 32'd0) total_r <= '0;
        else if (mag_val > 64'(LEN_MAX)) total_r <= LEN_MAX;
        else total_r <= mag_val[47:0];
      end
      OP_DIV_INIT: begin
        angle_q <= sing_r ? 25'd0 : ang_sh[24:0];
        quo     <= total_r;
        rem     <= '0;
      end
      OP_DIV: begin
        if (dtry >= {1'b0, count}) begin
          rem <= 32'(dtry - {1'b0, count});
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= dtry[31:0];
          quo <= {quo[46:0], 1'b0};
        end
      end
      OP_OUT: begin
        out_total  <= count;
        out_angle  <= angle_q;
        out_length <= total_r;
        out_mean   <= (count == 32'd0) ? 48'd0 : quo;
        out_ovf    <= ovf_r;
        out_sing   <= sing_r;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/vaa_controller.sv
module vaa_controller #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vaa_pkg::status_t status,
  output vaa_pkg::cmd_t    cmd
);
  import vaa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_ROTI, S_ROT, S_SCALE, S_ACC, S_EVAL, S_VEC, S_MAG, S_FIN,
    S_DIVI, S_DIV, S_OUT
  } state_t;

  state_t     state;
  logic [5:0] step;

  assign in_ready = (state == S_IDLE);
  assign cmd.step = step[4:0];

  always_comb begin
    unique case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      S_PHASE: cmd.op = status.clear_item ? OP_CLEAR : OP_PHASE;
      S_ROTI:  cmd.op = OP_ROT_INIT;
      S_ROT:   cmd.op = OP_ROT;
      S_SCALE: cmd.op = OP_SCALE;
      S_ACC:   cmd.op = OP_ACC;
      S_EVAL:  cmd.op = OP_VEC_INIT;
      S_VEC:   cmd.op = OP_VEC;
      S_MAG:   cmd.op = OP_MAG;
      S_FIN:   cmd.op = OP_FIN;
      S_DIVI:  cmd.op = OP_DIV_INIT;
      S_DIV:   cmd.op = OP_DIV;
      S_OUT:   cmd.op = status.out_free ? OP_OUT : OP_IDLE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_PHASE;
        S_PHASE: state <= status.clear_item ? S_EVAL : S_ROTI;
        S_ROTI: begin
          state <= S_ROT;
          step  <= '0;
        end
        S_ROT: begin
          if (step == 6'(CORDIC_STEPS - 1)) begin
            state <= S_SCALE;
            step  <= '0;
          end else step <= step + 6'd1;
        end
        S_SCALE: state <= S_ACC;
        S_ACC:   state <= S_EVAL;
        S_EVAL: begin
          state <= S_VEC;
          step  <= '0;
        end
        S_VEC: begin
          if (step == 6'(CORDIC_STEPS - 1)) begin
            state <= S_MAG;
            step  <= '0;
          end else step <= step + 6'd1;
        end
        S_MAG:  state <= S_FIN;
        S_FIN:  state <= S_DIVI;
        S_DIVI: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == 6'(LEN_BITS - 1)) begin
            state <= S_OUT;
            step  <= '0;
          end else step <= step + 6'd1;
        end
        S_OUT:   if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/vector_angle_averager.sv
// Circular mean of weighted angles.
// samples: req_type add/clear, angle_in and weight in signed Q16.16.
// results: one item per sample item: count, mean angle, total and mean
//   length, overflow and singular flags.
// cfg_we/cfg_index/cfg_data: index 0 angle unit, index 1 overflow limit;
//   write only while no item is in flight.
// An add item runs a CORDIC rotation, then a CORDIC vectoring pass, then
//   the one-bit-per-cycle 48-step length divider; a clear item skips the
//   rotation and goes straight to vectoring the sums. The two CORDIC passes
//   share the step counter and arctangent table but use separate registers.
// One item is worked at a time; samples.ready is high only when idle, so
//   no new item is taken until the last result is in the output register.
// A result waits in the output register while the next item is taken in;
//   if results stays stalled, the block holds at its final step.
// Reset (rst, synchronous) clears the sums and count, sets radians and a
//   limit of 10000, and drops results.valid.
module vector_angle_averager #(
  parameter int CORDIC_STEPS = 24,
  parameter int FRAC_BITS    = 16,
  parameter int ACC_BITS     = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  vaa_in_if.sink      samples,
  vaa_out_if.source   results
);
  import vaa_pkg::*;

  cmd_t    cmd;
  status_t status;

  vaa_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(samples.valid), .in_ready(samples.ready),
    .status(status), .cmd(cmd)
  );

  vaa_datapath #(.FRAC_BITS(FRAC_BITS), .ACC_BITS(ACC_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .status(status),
    .in_req_type(samples.req_type), .in_angle(samples.angle_in),
    .in_weight(samples.weight),
    .out_valid(results.valid), .out_ready(results.ready),
    .out_total(results.sample_total), .out_angle(results.mean_angle),
    .out_length(results.total_length), .out_mean(results.mean_length),
    .out_ovf(results.overflow_flag), .out_sing(results.singular_flag)
  );

endmodule

// File: rtl/vaa_checker.sv
module vaa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_total,
  input logic [24:0] mean_angle,
  input logic [47:0] total_length,
  input logic [47:0] mean_length,
  input logic        singular_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(total_length) && $stable(sample_total))
    else $error("result changed while stalled");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular_flag |-> mean_angle == 25'd0 && total_length == 48'd0)
    else $error("singular result with nonzero direction or length");

  a_mean_le: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mean_length <= total_length)
    else $error("mean length above total length");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind vector_angle_averager vaa_checker u_vaa_chk (
  .clk(clk), .rst(rst),
  .in_valid(samples.valid), .in_ready(samples.ready),
  .out_valid(results.valid), .out_ready(results.ready),
  .sample_total(results.sample_total), .mean_angle(results.mean_angle),
  .total_length(results.total_length), .mean_length(results.mean_length),
  .singular_flag(results.singular_flag)
);
